FILE: rtl/mcw_pkg.sv
// Package for the microcode container walker: record kinds, error codes,
// container constants and the queue word passed from front to back.
// No dependencies.
package mcw_pkg;

	// record kinds reported on the result channel
	localparam logic [2:0] KIND_HDR_OK = 3'd0;
	localparam logic [2:0] KIND_EQUIV  = 3'd1;
	localparam logic [2:0] KIND_TEND   = 3'd2;
	localparam logic [2:0] KIND_SECT   = 3'd3;
	localparam logic [2:0] KIND_PATCH  = 3'd4;
	localparam logic [2:0] KIND_ERROR  = 3'd5;
	localparam logic [2:0] KIND_END    = 3'd6;

	// error codes carried in half_c of an error record
	localparam logic [15:0] ERR_SHORT_HDR = 16'd0;
	localparam logic [15:0] ERR_BAD_HDR   = 16'd1;
	localparam logic [15:0] ERR_SECT_TYPE = 16'd2;
	localparam logic [15:0] ERR_SECT_SIZE = 16'd3;

	localparam logic [31:0] HDR_MAGIC    = 32'h0041_4d44;
	localparam logic [31:0] TABLE_TYPE   = 32'h0000_0000;
	localparam logic [31:0] SECTION_TYPE = 32'h0000_0001;
	localparam logic [31:0] PATCH_HDR_SZ = 32'd64;

	localparam int MCW_QUEUE_DEPTH = 4;

	// One queue word holds everything a single byte produces: an optional
	// full record, then an optional zero-data record (table end or end).
	typedef struct packed {
		logic        has_first;
		logic [2:0]  kind;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [15:0] half_c;
		logic [15:0] half_d;
		logic        flag;
		logic        has_second;
		logic [2:0]  second_kind;
		logic        second_flag;
		logic [31:0] position;
	} mcw_entry_t;

endpackage

FILE: rtl/mcw_front.sv
// Front end of the container walker: takes one byte per word, tracks the
// parse phase and builds the records that byte causes. Depends on mcw_pkg.
module mcw_front import mcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_blob,
	output logic       push,
	output mcw_entry_t entry
);

	localparam logic [2:0] PH_HDR   = 3'd0;
	localparam logic [2:0] PH_EQUIV = 3'd1;
	localparam logic [2:0] PH_PAD   = 3'd2;
	localparam logic [2:0] PH_SECT  = 3'd3;
	localparam logic [2:0] PH_PATCH = 3'd4;
	localparam logic [2:0] PH_BODY  = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;

	logic [2:0]  phase_q, phase_n;
	logic [5:0]  off_q, off_n;
	logic [31:0] pos_q, pos_n, pos_inc;
	logic [31:0] shift_q, shift_n;
	logic [31:0] cap_a_q, cap_a_n, cap_b_q, cap_b_n;
	logic [15:0] cap_c_q, cap_c_n;
	logic [31:0] region_q, region_n, region_dec;
	logic [31:0] skip_q, skip_n, skip_dec;
	logic        tend_chk, mid;

	assign pos_inc    = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
	assign region_dec = region_q - 32'd1;
	assign skip_dec   = skip_q - 32'd1;

	always_comb begin
		phase_n  = phase_q;
		off_n    = off_q;
		pos_n    = pos_inc;
		cap_a_n  = cap_a_q;
		cap_b_n  = cap_b_q;
		cap_c_n  = cap_c_q;
		region_n = region_q;
		skip_n   = skip_q;
		tend_chk = 1'b0;
		mid      = 1'b0;
		entry    = '0;
		entry.position = pos_inc;

		// hold the shift line while the unused tail of a patch header passes
		if (phase_q == PH_PATCH && off_q >= 6'd26)
			shift_n = shift_q;
		else
			shift_n = {data_byte, shift_q[31:8]};

		case (phase_q)
			PH_HDR: begin
				if (off_q == 6'd3) cap_a_n = shift_n;
				if (off_q == 6'd7) cap_b_n = shift_n;
				if (off_q == 6'd11) begin
					off_n = '0;
					entry.has_first = 1'b1;
					if (cap_a_q != HDR_MAGIC || cap_b_q != TABLE_TYPE || shift_n == '0) begin
						entry.kind   = KIND_ERROR;
						entry.half_c = ERR_BAD_HDR;
						phase_n      = PH_DONE;
					end else begin
						entry.kind   = KIND_HDR_OK;
						entry.word_a = shift_n;
						region_n     = shift_n;
						phase_n      = PH_EQUIV;
					end
				end else begin
					off_n = off_q + 6'd1;
				end
			end
			PH_EQUIV: begin
				if (off_q == 6'd3)  cap_a_n = shift_n;
				if (off_q == 6'd13) cap_c_n = shift_n[31:16];
				region_n = region_dec;
				if (off_q == 6'd15) begin
					off_n = '0;
					entry.has_first = 1'b1;
					if (cap_a_q != '0) begin
						entry.kind   = KIND_EQUIV;
						entry.word_a = cap_a_q;
						entry.half_c = cap_c_q;
						tend_chk     = 1'b1;
					end else begin
						// terminator entry closes the table
						entry.kind = KIND_TEND;
						entry.flag = (region_dec != '0);
						phase_n    = (region_dec != '0) ? PH_PAD : PH_SECT;
					end
				end else begin
					off_n    = off_q + 6'd1;
					tend_chk = 1'b1;
				end
				// region exhausted before a terminator: end the table, drop any partial entry
				if (tend_chk && region_dec == '0 && !end_of_blob) begin
					entry.has_second  = 1'b1;
					entry.second_kind = KIND_TEND;
					entry.second_flag = 1'b1;
					off_n             = '0;
					phase_n           = PH_SECT;
				end
			end
			PH_PAD: begin
				region_n = region_dec;
				if (region_dec == '0) phase_n = PH_SECT;
			end
			PH_SECT: begin
				if (off_q == 6'd3) cap_a_n = shift_n;
				if (off_q == 6'd3 && shift_n != SECTION_TYPE) begin
					entry.has_first = 1'b1;
					entry.kind      = KIND_ERROR;
					entry.word_a    = shift_n;
					entry.half_c    = ERR_SECT_TYPE;
					off_n           = '0;
					phase_n         = PH_DONE;
				end else if (off_q == 6'd7) begin
					off_n = '0;
					entry.has_first = 1'b1;
					entry.word_a    = shift_n;
					if (shift_n < PATCH_HDR_SZ) begin
						entry.kind   = KIND_ERROR;
						entry.half_c = ERR_SECT_SIZE;
						phase_n      = PH_DONE;
					end else begin
						entry.kind = KIND_SECT;
						skip_n     = shift_n - PATCH_HDR_SZ;
						phase_n    = PH_PATCH;
					end
				end else begin
					off_n = off_q + 6'd1;
				end
			end
			PH_PATCH: begin
				if (off_q == 6'd3) cap_a_n = shift_n;
				if (off_q == 6'd7) cap_b_n = shift_n;
				if (off_q == 6'd9) cap_c_n = shift_n[31:16];
				if (off_q == 6'd63) begin
					off_n = '0;
					entry.has_first = 1'b1;
					entry.kind      = KIND_PATCH;
					entry.word_a    = cap_a_q;
					entry.word_b    = cap_b_q;
					entry.half_c    = cap_c_q;
					entry.half_d    = shift_n[31:16];
					phase_n         = (skip_q != '0) ? PH_BODY : PH_SECT;
				end else begin
					off_n = off_q + 6'd1;
				end
			end
			PH_BODY: begin
				skip_n = skip_dec;
				if (skip_dec == '0) phase_n = PH_SECT;
			end
			default: begin
			end
		endcase

		if (end_of_blob) begin
			case (phase_n)
				PH_HDR: begin
					entry.has_first = 1'b1;
					entry.kind      = KIND_ERROR;
					entry.half_c    = ERR_SHORT_HDR;
					mid             = 1'b1;
				end
				PH_EQUIV, PH_PAD, PH_BODY: mid = 1'b1;
				PH_DONE:                   mid = 1'b0;
				default:                   mid = (off_n != '0);
			endcase
			entry.has_second  = 1'b1;
			entry.second_kind = KIND_END;
			entry.second_flag = mid;
			phase_n = PH_HDR;
			off_n   = '0;
			pos_n   = '0;
		end
	end

	assign push = accept && (entry.has_first || entry.has_second);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			off_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			off_q   <= off_n;
			pos_q   <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q  <= shift_n;
			cap_a_q  <= cap_a_n;
			cap_b_q  <= cap_b_n;
			cap_c_q  <= cap_c_n;
			region_q <= region_n;
			skip_q   <= skip_n;
		end
	end

endmodule

FILE: rtl/mcw_queue.sv
// Short register queue between walker front and back.
// Depends on mcw_pkg for the queue word type.
module mcw_queue import mcw_pkg::*; #(
	parameter int DEPTH = MCW_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mcw_entry_t wr_entry,
	input  logic       pop,
	output mcw_entry_t head,
	output logic       full,
	output logic       empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	mcw_entry_t          store_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_ptr_q] <= wr_entry;
	end

endmodule

FILE: rtl/mcw_back.sv
// Back end of the container walker: drains queue words into the registered
// result channel, one or two records per word. Depends on mcw_pkg.
module mcw_back import mcw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  mcw_entry_t   head,
	input  logic         empty,
	output logic         pop,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	logic        valid_q, second_q;
	logic [2:0]  kind_q;
	logic [31:0] word_a_q, word_b_q, pos_q;
	logic [15:0] half_c_q, half_d_q;
	logic        flag_q, last_q;
	logic        out_free, load, first_sel;

	assign out_free  = !valid_q || m_tready;
	assign load      = out_free && !empty;
	assign first_sel = head.has_first && !second_q;
	// release the queue word once its final record is loaded
	assign pop       = load && !(first_sel && head.has_second);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= !empty;
			if (load)
				second_q <= first_sel && head.has_second;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_q <= head.position;
			if (first_sel) begin
				kind_q   <= head.kind;
				word_a_q <= head.word_a;
				word_b_q <= head.word_b;
				half_c_q <= head.half_c;
				half_d_q <= head.half_d;
				flag_q   <= head.flag;
				last_q   <= !head.has_second;
			end else begin
				kind_q   <= head.second_kind;
				word_a_q <= '0;
				word_b_q <= '0;
				half_c_q <= '0;
				half_d_q <= '0;
				flag_q   <= head.second_flag;
				last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, pos_q, flag_q, half_d_q, half_c_q, word_b_q, word_a_q};

endmodule

FILE: rtl/microcode_container_walker.sv
// Top level of the microcode container walker: front parser, word queue and
// result back end. Depends on mcw_pkg, mcw_front, mcw_queue and mcw_back.
//
// Usage: feed the container blob one byte per word on the s_ channel, with
// s_tlast on the final byte. Each byte may cause zero, one or two records on
// the m_ channel (header ok, equivalence entry, table end, section, patch
// header, error, end); m_tlast marks the last record caused by that byte.
// The front takes one byte every cycle while the queue has room; a byte's
// records pass through the queue into the output register behind m_tvalid.
// A byte with two records occupies the output for both, so the byte rate is
// bounded by the single output register draining one record per cycle while
// m_tready is high. When the receiver stalls, records collect in the queue
// (QUEUE_DEPTH words) and s_tready drops only once it is full. Reset clears
// the parse phase, offsets, position counter, queue and output valid; no
// clearing pass is needed, the first byte may arrive right after reset.
// After an end-of-blob byte the walker is back in its header phase.
module microcode_container_walker import mcw_pkg::*; #(
	parameter int QUEUE_DEPTH = MCW_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end_of_blob
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] word_a, [63:32] word_b, [79:64] half_c, [95:80] half_d,
	// [96] status_flag, [128:97] byte_position, [135:129] zero
	output logic [135:0] m_tdata,
	output logic [2:0]   m_tuser,   // [2:0] record_kind
	output logic         m_tlast    // run_last
);

	mcw_entry_t entry, head;
	logic       accept, push, pop, full, empty;

	// take a byte whenever the queue can hold what it produces
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	mcw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (s_tdata),
		.end_of_blob (s_tlast),
		.push        (push),
		.entry       (entry)
	);

	mcw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	mcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
